>>> design/pcbt_pkg.sv
package pcbt_pkg;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int CNT_VAL_W  = 13;
  localparam int TV_W       = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Default sizes for the top level parameters
  localparam int COUNT_ENTRIES_DEF   = 64;
  localparam int BAN_ENTRIES_DEF     = 16;
  localparam int TRUSTED_ENTRIES_DEF = 4;

  localparam logic [CNT_VAL_W-1:0] MAXCONN_RESET = 13'd50;
  localparam logic [CNT_VAL_W-1:0] COUNT_MAX     = 13'h1FFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXCONN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TVALID    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TADDR0    = 3'd3;

  // Request types
  localparam logic [1:0] REQ_SCAN  = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_BAN     = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] client_addr;
    logic              busy_read;
  } req_item_t;

  typedef struct packed {
    logic [1:0]           result_kind;
    logic [ADDR_W-1:0]    addr;
    logic                 drop;
    logic [CNT_VAL_W-1:0] conn_count;
    logic                 table_overflow;
    logic                 last;
  } res_item_t;

  // Status from the shared compare unit
  typedef struct packed {
    logic                 eq;
    logic                 ge;
    logic [CNT_VAL_W-1:0] cnt_inc;
  } match_res_t;

endpackage

>>> design/pcbt_match.sv
module pcbt_match
  import pcbt_pkg::*;
(
  input  logic                 sel_ban,
  input  logic [ADDR_W-1:0]    key_q,
  input  logic [ADDR_W-1:0]    ban_q,
  input  logic [ADDR_W-1:0]    probe,
  input  logic [CNT_VAL_W-1:0] cnt,
  input  logic [CNT_VAL_W-1:0] thr,
  output match_res_t           res
);

  logic [ADDR_W-1:0] operand;

  // One address comparator shared by the count-table walk and the ban-list walk
  assign operand = sel_ban ? ban_q : key_q;

  always_comb begin
    res.eq      = (operand == probe);
    res.ge      = (cnt >= thr);
    // saturating increment of a stored count
    res.cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + CNT_VAL_W'(1);
  end

endmodule

>>> design/pcbt_trust.sv
module pcbt_trust
  import pcbt_pkg::*;
#(
  parameter int TRUSTED_ENTRIES = TRUSTED_ENTRIES_DEF
) (
  input  logic [TV_W-1:0]                        tvalid,
  input  logic [TRUSTED_ENTRIES-1:0][ADDR_W-1:0] taddr,
  input  logic [ADDR_W-1:0]                      key,
  output logic                                   trusted
);

  // Any in-use trusted slot holding this address
  always_comb begin
    trusted = 1'b0;
    for (int t = 0; t < TRUSTED_ENTRIES; t++) begin
      if (tvalid[t] && (taddr[t] == key)) begin
        trusted = 1'b1;
      end
    end
  end

endmodule

>>> design/per_client_connection_ban_table.sv
// Channel  | Signals                          | Direction | Transaction
// ---------+----------------------------------+-----------+------------------------------
// request  | req_valid, req_ready, req_item   | in        | scan slot, end of scan, check
// result   | res_valid, res_ready, res_item   | out       | verdict, banned addr, done
// config   | cfg_we, cfg_index, cfg_data      | in        | register write, no wait
//
// Scan slot: walks the count table through one comparator.
// Connection check: walk of the ban list (skipped when disabled), then the verdict, which
// waits while the result side stalls.
// End of scan: each counted client is read, then checked; each ban and the done result
// wait while the result side stalls.
// Reset empties both tables through their fill counts; no clearing pass is needed.
// req_ready is high only while the sequencer is idle; a pending result does not block it.
module per_client_connection_ban_table
  import pcbt_pkg::*;
#(
  parameter int COUNT_ENTRIES   = COUNT_ENTRIES_DEF,
  parameter int BAN_ENTRIES     = BAN_ENTRIES_DEF,
  parameter int TRUSTED_ENTRIES = TRUSTED_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_item_t             req_item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_item_t             res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(COUNT_ENTRIES + 1);
  localparam int CIW   = $clog2(COUNT_ENTRIES);
  localparam int BAN_W = $clog2(BAN_ENTRIES + 1);
  localparam int BIW   = (BAN_ENTRIES > 1) ? $clog2(BAN_ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_CHECK, ST_VERDICT, ST_ES_RD, ST_ES_CHK, ST_ES_FIN
  } state_t;

  // Configuration registers
  logic                                   enable;
  logic [CNT_VAL_W-1:0]                   max_conn;
  logic [TV_W-1:0]                        tvalid;
  logic [TRUSTED_ENTRIES-1:0][ADDR_W-1:0] taddr;

  // Sequencer state
  state_t               state, state_next;
  req_item_t            cur, cur_next;
  logic [CNT_W-1:0]     cnt_ptr, cnt_ptr_next;
  logic [BAN_W-1:0]     ban_ptr, ban_ptr_next;
  logic                 cmp_vld, cmp_vld_next;
  logic [CIW-1:0]       cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]     count_used, count_used_next;
  logic [BAN_W-1:0]     ban_used, ban_used_next;
  logic                 overflow_seen, overflow_seen_next;
  logic                 drop_flag, drop_flag_next;

  // Memories
  logic [ADDR_W-1:0]    key_mem [COUNT_ENTRIES];
  logic [CNT_VAL_W-1:0] val_mem [COUNT_ENTRIES];
  logic [ADDR_W-1:0]    ban_mem [BAN_ENTRIES];
  logic [ADDR_W-1:0]    key_q;
  logic [CNT_VAL_W-1:0] val_q;
  logic [ADDR_W-1:0]    ban_q;

  logic                 cnt_rd_en, ban_rd_en, key_we, val_we, ban_we;
  logic [CIW-1:0]       cnt_rd_idx, cnt_wr_idx;
  logic [BIW-1:0]       ban_rd_idx;
  logic [CNT_VAL_W-1:0] val_wr_data;

  logic                 res_load, slot_free, req_fire, trusted;
  res_item_t            res_next;
  match_res_t           m;

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign slot_free = !res_valid || res_ready;

  // Shared compare unit
  pcbt_match u_match (
    .sel_ban (state == ST_CHECK),
    .key_q   (key_q),
    .ban_q   (ban_q),
    .probe   (cur.client_addr),
    .cnt     (val_q),
    .thr     (max_conn),
    .res     (m)
  );

  pcbt_trust #(
    .TRUSTED_ENTRIES (TRUSTED_ENTRIES)
  ) u_trust (
    .tvalid  (tvalid),
    .taddr   (taddr),
    .key     (key_q),
    .trusted (trusted)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable   <= 1'b1;
      max_conn <= MAXCONN_RESET;
      tvalid   <= '0;
      taddr    <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ENABLE)  enable   <= cfg_data[0];
      if (cfg_index == CFG_MAXCONN) max_conn <= cfg_data[CNT_VAL_W-1:0];
      if (cfg_index == CFG_TVALID)  tvalid   <= cfg_data[TV_W-1:0];
      for (int t = 0; t < TRUSTED_ENTRIES; t++) begin
        if (cfg_index == CFG_TADDR0 + CFG_IDX_W'(t)) taddr[t] <= cfg_data[ADDR_W-1:0];
      end
    end
  end

  // Count table: one read port, one write port, registered read
  always_ff @(posedge clk) begin
    if (key_we) key_mem[cnt_wr_idx] <= cur.client_addr;
    if (val_we) val_mem[cnt_wr_idx] <= val_wr_data;
    if (cnt_rd_en) begin
      key_q <= key_mem[cnt_rd_idx];
      val_q <= val_mem[cnt_rd_idx];
    end
  end

  // Ban list
  always_ff @(posedge clk) begin
    if (ban_we) ban_mem[ban_used[BIW-1:0]] <= key_q;
    if (ban_rd_en) ban_q <= ban_mem[ban_rd_idx];
  end

  assign cnt_rd_idx = cnt_ptr[CIW-1:0];
  assign ban_rd_idx = ban_ptr[BIW-1:0];

  // Sequencer next state
  always_comb begin
    state_next         = state;
    cur_next           = cur;
    cnt_ptr_next       = cnt_ptr;
    ban_ptr_next       = ban_ptr;
    cmp_vld_next       = 1'b0;
    cmp_idx_next       = cmp_idx;
    count_used_next    = count_used;
    ban_used_next      = ban_used;
    overflow_seen_next = overflow_seen;
    drop_flag_next     = drop_flag;
    cnt_rd_en          = 1'b0;
    ban_rd_en          = 1'b0;
    key_we             = 1'b0;
    val_we             = 1'b0;
    ban_we             = 1'b0;
    cnt_wr_idx         = cmp_idx;
    val_wr_data        = m.cnt_inc;
    res_load           = 1'b0;
    res_next           = '0;

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          cur_next     = req_item;
          cnt_ptr_next = '0;
          ban_ptr_next = '0;
          case (req_item.req_type)
            REQ_SCAN: begin
              if (enable && req_item.busy_read) state_next = ST_SCAN;
            end
            REQ_END: begin
              if (enable) begin
                ban_used_next = '0;
                state_next    = ST_ES_RD;
              end
            end
            REQ_CHECK: begin
              if (enable) begin
                state_next = ST_CHECK;
              end else begin
                drop_flag_next = 1'b0;
                state_next     = ST_VERDICT;
              end
            end
            default: ;
          endcase
        end
      end

      // Stream the count table looking for the slot's address
      ST_SCAN: begin
        if (cmp_vld && m.eq) begin
          val_we     = 1'b1;
          state_next = ST_IDLE;
        end else if (!cmp_vld && (cnt_ptr == count_used)) begin
          if (count_used < CNT_W'(COUNT_ENTRIES)) begin
            cnt_wr_idx      = count_used[CIW-1:0];
            key_we          = 1'b1;
            val_we          = 1'b1;
            val_wr_data     = CNT_VAL_W'(1);
            count_used_next = count_used + CNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          state_next = ST_IDLE;
        end else if (cnt_ptr != count_used) begin
          cnt_rd_en    = 1'b1;
          cmp_vld_next = 1'b1;
          cmp_idx_next = cnt_ptr[CIW-1:0];
          cnt_ptr_next = cnt_ptr + CNT_W'(1);
        end
      end

      // Stream the ban list looking for the arriving address
      ST_CHECK: begin
        if (cmp_vld && m.eq) begin
          drop_flag_next = 1'b1;
          state_next     = ST_VERDICT;
        end else if (!cmp_vld && (ban_ptr == ban_used)) begin
          drop_flag_next = 1'b0;
          state_next     = ST_VERDICT;
        end else if (ban_ptr != ban_used) begin
          ban_rd_en    = 1'b1;
          cmp_vld_next = 1'b1;
          ban_ptr_next = ban_ptr + BAN_W'(1);
        end
      end

      ST_VERDICT: begin
        if (slot_free) begin
          res_load             = 1'b1;
          res_next.result_kind = KIND_VERDICT;
          res_next.addr        = cur.client_addr;
          res_next.drop        = drop_flag;
          res_next.last        = 1'b1;
          state_next           = ST_IDLE;
        end
      end

      // End of scan: read one counted client
      ST_ES_RD: begin
        if (cnt_ptr == count_used) begin
          state_next = ST_ES_FIN;
        end else begin
          cnt_rd_en    = 1'b1;
          cnt_ptr_next = cnt_ptr + CNT_W'(1);
          state_next   = ST_ES_CHK;
        end
      end

      // End of scan: decide on that client, wait for the result slot if banned
      ST_ES_CHK: begin
        if (!(m.ge && !trusted)) begin
          state_next = ST_ES_RD;
        end else if (ban_used == BAN_W'(BAN_ENTRIES)) begin
          overflow_seen_next = 1'b1;
          state_next         = ST_ES_RD;
        end else if (slot_free) begin
          ban_we               = 1'b1;
          ban_used_next        = ban_used + BAN_W'(1);
          res_load             = 1'b1;
          res_next.result_kind = KIND_BAN;
          res_next.addr        = key_q;
          res_next.conn_count  = val_q;
          state_next           = ST_ES_RD;
        end
      end

      ST_ES_FIN: begin
        if (slot_free) begin
          res_load                = 1'b1;
          res_next.result_kind    = KIND_DONE;
          res_next.table_overflow = overflow_seen;
          res_next.last           = 1'b1;
          count_used_next         = '0;
          overflow_seen_next      = 1'b0;
          state_next              = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt_ptr       <= '0;
      ban_ptr       <= '0;
      cmp_vld       <= 1'b0;
      count_used    <= '0;
      ban_used      <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      cnt_ptr       <= cnt_ptr_next;
      ban_ptr       <= ban_ptr_next;
      cmp_vld       <= cmp_vld_next;
      count_used    <= count_used_next;
      ban_used      <= ban_used_next;
      overflow_seen <= overflow_seen_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    cur       <= cur_next;
    cmp_idx   <= cmp_idx_next;
    drop_flag <= drop_flag_next;
    if (res_load) res_item <= res_next;
  end

  // Checks
  a_count_insert_room: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (count_used < CNT_W'(COUNT_ENTRIES)))
    else $error("count table insert while full");

  a_ban_insert_room: assert property (@(posedge clk) disable iff (rst)
    ban_we |-> (ban_used < BAN_W'(BAN_ENTRIES)))
    else $error("ban list insert while full");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ES_FIN && slot_free) |=>
      (count_used == '0 && !overflow_seen && res_valid && res_item.last))
    else $error("scan finish did not clear the count table");

  a_ban_over_limit: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_next.result_kind == KIND_BAN) |=>
      (res_valid && res_item.conn_count >= max_conn))
    else $error("banned client below the limit");

endmodule
